// File: rtl/ovtrk_pkg.sv
package ovtrk_pkg;

  localparam int DATA_W  = 32;
  localparam int UDATA_W = 31;
  localparam int ADDR_W  = 5;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [UDATA_W-1:0]       uword_t;
  typedef logic [1:0]               opcode_t;

  localparam opcode_t OP_TICK  = 2'd0;
  localparam opcode_t OP_POSE  = 2'd1;
  localparam opcode_t OP_RANGE = 2'd2;

  localparam logic [2:0] REG_SPEED  = 3'd0;
  localparam logic [2:0] REG_KP     = 3'd1;
  localparam logic [2:0] REG_KI     = 3'd2;
  localparam logic [2:0] REG_KD     = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;
  localparam logic [2:0] REG_HALF   = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;

  localparam word_t  RST_SPEED  = 32'sd65536;
  localparam word_t  RST_KP     = 32'sd6554;
  localparam word_t  RST_KI     = 32'sd0;
  localparam word_t  RST_KD     = 32'sd0;
  localparam uword_t RST_THRESH = 31'd19661;
  localparam uword_t RST_HALF   = 31'd393216;
  localparam uword_t RST_RADIUS = 31'd393216;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEOM,
    ST_SQ,
    ST_ROOT,
    ST_INTEG,
    ST_MSTART,
    ST_MUL,
    ST_ADD1,
    ST_ADD2,
    ST_OUT
  } state_t;

endpackage

// File: rtl/ovtrk_if.sv
interface ovtrk_cmd_if;
  logic               valid;
  logic               ready;
  ovtrk_pkg::opcode_t opcode;
  ovtrk_pkg::word_t   pos_x;
  ovtrk_pkg::word_t   pos_y;
  ovtrk_pkg::uword_t  range_value;

  modport source (output valid, opcode, pos_x, pos_y, range_value, input ready);
  modport sink (input valid, opcode, pos_x, pos_y, range_value, output ready);
endinterface

interface ovtrk_drv_if;
  logic             valid;
  logic             ready;
  ovtrk_pkg::word_t linear_speed;
  ovtrk_pkg::word_t angular_rate;
  ovtrk_pkg::word_t track_error;
  logic             drive_enabled;

  modport source (output valid, linear_speed, angular_rate, track_error, drive_enabled,
                  input ready);
  modport sink (input valid, linear_speed, angular_rate, track_error, drive_enabled,
                output ready);
endinterface

// File: rtl/ovtrk_smul.sv
module ovtrk_smul #(
  parameter int AW = 32,
  parameter int BW = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  prod
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW:0] mcand;
  logic [BW-1:0]      mplier;
  logic signed [AW:0] hi;
  logic [BW-1:0]      lo;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               last;
  logic signed [AW:0] addend;
  logic signed [AW:0] psum;

  // radix-2 shift-add; the sign bit of b carries negative weight
  always_comb begin
    last = (cnt == CW'(BW - 1));
    if (!mplier[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
    psum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        hi     <= '0;
        mcand  <= {a[AW-1], a};
        mplier <= b;
      end else if (busy) begin
        hi     <= {psum[AW], psum[AW:1]};
        lo     <= {psum[0], lo[BW-1:1]};
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = {hi[AW-1:0], lo};

endmodule

// File: rtl/ovtrk_isqrt.sv
module ovtrk_isqrt #(
  parameter int RW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RW-1:0]     radicand,
  output logic              done,
  output logic [RW/2-1:0]   root
);

  localparam int HW = RW / 2;
  localparam int CW = $clog2(HW);

  logic [RW-1:0]   rad;
  logic [HW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            last;
  logic [HW+3:0]   cand;
  logic [HW+3:0]   trial;
  logic [HW+3:0]   diff;
  logic            ge;

  // restoring root, two radicand bits per step
  always_comb begin
    last  = (cnt == CW'(HW - 1));
    cand  = {rem, rad[RW-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge    = (cand >= trial);
    diff  = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        rad  <= radicand;
      end else if (busy) begin
        rem  <= ge ? diff[HW+1:0] : cand[HW+1:0];
        root <= {root[HW-2:0], ge};
        rad  <= rad << 2;
        cnt  <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/oval_track_pid_steering.sv
// Oval-track PID steering.
// cmd channel (valid/ready): opcode selects a pose update (pos_x, pos_y), a range
// sample (range_value, sets a sticky obstacle flag below the threshold) or a
// control tick. Each tick yields one transaction on the drv channel; the other
// opcodes yield none. Registers are to be written over the APB port only while
// idle; the block itself does not enforce this. A tick walks through bit-serial
// units: two 33x33 squarers run in parallel, the square root gives one result
// bit per cycle, and three gain multipliers run in parallel, followed by the
// control and add states.
// A tick on a straight side skips the squarers and the square root; a tick with
// the obstacle flag set goes straight to the output state.
// cmd.ready is high only between transactions. The result sits in an output
// register: further pose and range transactions are taken while it waits, and a
// following tick is computed but held until drv.ready frees the register.
// Reset (rst, synchronous) restores register defaults, clears pose, obstacle flag
// and PID state, and empties the output register.
module oval_track_pid_steering #(
  parameter int FRAC_BITS = 16,
  parameter int SUM_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ovtrk_pkg::ADDR_W-1:0]    paddr,
  input  logic [ovtrk_pkg::DATA_W-1:0]    pwdata,
  output logic [ovtrk_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  ovtrk_cmd_if.sink                       cmd,
  ovtrk_drv_if.source                     drv
);

  localparam int DW    = ovtrk_pkg::DATA_W;
  localparam int MB    = (SUM_WIDTH > DW) ? SUM_WIDTH : DW + 1;
  localparam int PW    = DW + MB;
  localparam int ACC_W = PW + 2;
  localparam int SQ_W  = DW + 1;
  localparam int EW    = DW + 2;

  ovtrk_pkg::state_t state;
  ovtrk_pkg::state_t state_next;

  ovtrk_pkg::word_t  forward_speed;
  ovtrk_pkg::word_t  gain_proportional;
  ovtrk_pkg::word_t  gain_integral;
  ovtrk_pkg::word_t  gain_derivative;
  ovtrk_pkg::uword_t obstacle_threshold;
  ovtrk_pkg::uword_t oval_half_length;
  ovtrk_pkg::uword_t oval_radius;

  ovtrk_pkg::word_t             cur_x;
  ovtrk_pkg::word_t             cur_y;
  logic                         obstacle_seen;
  logic signed [SUM_WIDTH-1:0]  error_sum;
  ovtrk_pkg::word_t             prev_error;
  ovtrk_pkg::word_t             err;
  logic signed [DW:0]           diff;
  logic signed [ACC_W-1:0]      acc;

  logic             out_valid;
  ovtrk_pkg::word_t out_speed;
  ovtrk_pkg::word_t out_rate;
  ovtrk_pkg::word_t out_error;
  logic             out_en;

  logic sq_start, root_start, mul_start;
  logic sqx_done, sqy_done, root_done, p_done, i_done, d_done;
  logic signed [2*SQ_W-1:0] sqx_prod, sqy_prod;
  logic [DW-1:0]            root;
  logic signed [PW-1:0]     p_prod, i_prod, d_prod;

  logic signed [SQ_W-1:0] x_e, y_e, hl_e, dx_right, dx_left, dx_sel;
  logic                   on_right, on_left, on_end;
  logic signed [EW-1:0]   y_w, r_w, root_w, straight_w, end_w;
  logic [2*DW-1:0]        rad_in;
  logic signed [SUM_WIDTH:0] sum_w;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [DW:0]     diff_next;
  logic signed [ACC_W-1:0] shifted;
  ovtrk_pkg::word_t       rate;
  logic                   cfg_wr;
  logic                   out_free;

  function automatic ovtrk_pkg::word_t sat_word(input logic signed [EW-1:0] v);
    logic [2:0] top;
    top = v[EW-1 -: 3];
    if (top == 3'b000 || top == 3'b111) begin
      return v[DW-1:0];
    end else if (v[EW-1]) begin
      return {1'b1, {(DW-1){1'b0}}};
    end else begin
      return {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[4:2])
      ovtrk_pkg::REG_SPEED:  prdata = forward_speed;
      ovtrk_pkg::REG_KP:     prdata = gain_proportional;
      ovtrk_pkg::REG_KI:     prdata = gain_integral;
      ovtrk_pkg::REG_KD:     prdata = gain_derivative;
      ovtrk_pkg::REG_THRESH: prdata = {1'b0, obstacle_threshold};
      ovtrk_pkg::REG_HALF:   prdata = {1'b0, oval_half_length};
      ovtrk_pkg::REG_RADIUS: prdata = {1'b0, oval_radius};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed      <= ovtrk_pkg::RST_SPEED;
      gain_proportional  <= ovtrk_pkg::RST_KP;
      gain_integral      <= ovtrk_pkg::RST_KI;
      gain_derivative    <= ovtrk_pkg::RST_KD;
      obstacle_threshold <= ovtrk_pkg::RST_THRESH;
      oval_half_length   <= ovtrk_pkg::RST_HALF;
      oval_radius        <= ovtrk_pkg::RST_RADIUS;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        ovtrk_pkg::REG_SPEED:  forward_speed      <= pwdata;
        ovtrk_pkg::REG_KP:     gain_proportional  <= pwdata;
        ovtrk_pkg::REG_KI:     gain_integral      <= pwdata;
        ovtrk_pkg::REG_KD:     gain_derivative    <= pwdata;
        ovtrk_pkg::REG_THRESH: obstacle_threshold <= pwdata[ovtrk_pkg::UDATA_W-1:0];
        ovtrk_pkg::REG_HALF:   oval_half_length   <= pwdata[ovtrk_pkg::UDATA_W-1:0];
        ovtrk_pkg::REG_RADIUS: oval_radius        <= pwdata[ovtrk_pkg::UDATA_W-1:0];
        default: ;
      endcase
    end
  end

  // track geometry
  always_comb begin
    x_e      = SQ_W'(cur_x);
    y_e      = SQ_W'(cur_y);
    hl_e     = $signed({2'b00, oval_half_length});
    on_right = (x_e > hl_e);
    on_left  = (x_e < -hl_e);
    on_end   = on_right || on_left;
    dx_right = x_e - hl_e;
    dx_left  = x_e + hl_e;
    dx_sel   = on_right ? dx_right : dx_left;
    y_w      = EW'(cur_y);
    r_w      = $signed({3'b000, oval_radius});
    root_w   = $signed({2'b00, root});
    if (!cur_y[DW-1] && (cur_y != '0)) begin
      straight_w = y_w - r_w;
    end else begin
      straight_w = -r_w - y_w;
    end
    end_w    = root_w - r_w;
    rad_in   = sqx_prod[2*DW-1:0] + sqy_prod[2*DW-1:0];
  end

  // integral with saturation, difference term
  always_comb begin
    sum_w = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(err);
    if (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1]) begin
      sum_next = sum_w[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                  : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_next = sum_w[SUM_WIDTH-1:0];
    end
    diff_next = (DW+1)'(err) - (DW+1)'(prev_error);
  end

  // rate: floor shift and saturate
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    if ((&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1])) begin
      rate = shifted[DW-1:0];
    end else if (shifted[ACC_W-1]) begin
      rate = {1'b1, {(DW-1){1'b0}}};
    end else begin
      rate = {1'b0, {(DW-1){1'b1}}};
    end
  end

  ovtrk_smul #(.AW(SQ_W), .BW(SQ_W)) u_sq_x (
    .clk(clk), .rst(rst), .start(sq_start), .a(dx_sel), .b(dx_sel),
    .done(sqx_done), .prod(sqx_prod)
  );

  ovtrk_smul #(.AW(SQ_W), .BW(SQ_W)) u_sq_y (
    .clk(clk), .rst(rst), .start(sq_start), .a(y_e), .b(y_e),
    .done(sqy_done), .prod(sqy_prod)
  );

  ovtrk_isqrt #(.RW(2*DW)) u_root (
    .clk(clk), .rst(rst), .start(root_start), .radicand(rad_in),
    .done(root_done), .root(root)
  );

  ovtrk_smul #(.AW(DW), .BW(MB)) u_mul_p (
    .clk(clk), .rst(rst), .start(mul_start), .a(gain_proportional), .b(MB'(err)),
    .done(p_done), .prod(p_prod)
  );

  ovtrk_smul #(.AW(DW), .BW(MB)) u_mul_i (
    .clk(clk), .rst(rst), .start(mul_start), .a(gain_integral), .b(MB'(error_sum)),
    .done(i_done), .prod(i_prod)
  );

  ovtrk_smul #(.AW(DW), .BW(MB)) u_mul_d (
    .clk(clk), .rst(rst), .start(mul_start), .a(gain_derivative), .b(MB'(diff)),
    .done(d_done), .prod(d_prod)
  );

  // control
  assign cmd.ready = (state == ovtrk_pkg::ST_IDLE);
  assign out_free  = !out_valid || drv.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ovtrk_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    root_start = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      ovtrk_pkg::ST_IDLE: begin
        if (cmd.valid && cmd.opcode == ovtrk_pkg::OP_TICK) begin
          state_next = obstacle_seen ? ovtrk_pkg::ST_OUT : ovtrk_pkg::ST_GEOM;
        end
      end
      ovtrk_pkg::ST_GEOM: begin
        if (on_end) begin
          sq_start   = 1'b1;
          state_next = ovtrk_pkg::ST_SQ;
        end else begin
          state_next = ovtrk_pkg::ST_INTEG;
        end
      end
      ovtrk_pkg::ST_SQ: begin
        if (sqx_done) begin
          root_start = 1'b1;
          state_next = ovtrk_pkg::ST_ROOT;
        end
      end
      ovtrk_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = ovtrk_pkg::ST_INTEG;
        end
      end
      ovtrk_pkg::ST_INTEG:  state_next = ovtrk_pkg::ST_MSTART;
      ovtrk_pkg::ST_MSTART: begin
        mul_start  = 1'b1;
        state_next = ovtrk_pkg::ST_MUL;
      end
      ovtrk_pkg::ST_MUL: begin
        if (p_done) begin
          state_next = ovtrk_pkg::ST_ADD1;
        end
      end
      ovtrk_pkg::ST_ADD1: state_next = ovtrk_pkg::ST_ADD2;
      ovtrk_pkg::ST_ADD2: state_next = ovtrk_pkg::ST_OUT;
      ovtrk_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = ovtrk_pkg::ST_IDLE;
        end
      end
      default: state_next = ovtrk_pkg::ST_IDLE;
    endcase
  end

  // datapath and state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      obstacle_seen <= 1'b0;
      error_sum     <= '0;
      prev_error    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && drv.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ovtrk_pkg::ST_IDLE: begin
          if (cmd.valid && cmd.opcode == ovtrk_pkg::OP_POSE) begin
            cur_x <= cmd.pos_x;
            cur_y <= cmd.pos_y;
          end
          if (cmd.valid && cmd.opcode == ovtrk_pkg::OP_RANGE &&
              cmd.range_value < obstacle_threshold) begin
            obstacle_seen <= 1'b1;
          end
        end
        ovtrk_pkg::ST_GEOM: begin
          if (!on_end) begin
            err <= sat_word(straight_w);
          end
        end
        ovtrk_pkg::ST_ROOT: begin
          if (root_done) begin
            err <= sat_word(end_w);
          end
        end
        ovtrk_pkg::ST_INTEG: begin
          error_sum  <= sum_next;
          diff       <= diff_next;
          prev_error <= err;
        end
        ovtrk_pkg::ST_ADD1: acc <= ACC_W'(p_prod) + ACC_W'(i_prod);
        ovtrk_pkg::ST_ADD2: acc <= acc + ACC_W'(d_prod);
        ovtrk_pkg::ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (obstacle_seen) begin
              out_speed <= '0;
              out_rate  <= '0;
              out_error <= '0;
              out_en    <= 1'b0;
            end else begin
              out_speed <= forward_speed;
              out_rate  <= rate;
              out_error <= err;
              out_en    <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign drv.valid         = out_valid;
  assign drv.linear_speed  = out_speed;
  assign drv.angular_rate  = out_rate;
  assign drv.track_error   = out_error;
  assign drv.drive_enabled = out_en;

  a_obstacle_sticky: assert property (@(posedge clk) disable iff (rst)
    obstacle_seen |=> obstacle_seen)
    else $error("obstacle flag cleared outside reset");

  a_obstacle_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready && cmd.opcode == ovtrk_pkg::OP_TICK && obstacle_seen
    |=> state == ovtrk_pkg::ST_OUT)
    else $error("obstacle tick did not go straight to output");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    p_done |-> i_done && d_done)
    else $error("gain multipliers out of step");

  a_sq_lockstep: assert property (@(posedge clk) disable iff (rst)
    sqx_done |-> sqy_done)
    else $error("squarers out of step");

endmodule

// File: dv/oval_track_pid_steering_tb.sv
`timescale 1ns / 1ps

module oval_track_pid_steering_tb;
  import ovtrk_pkg::*;

  localparam int FRAC = 16;
  localparam int SUM_W = 48;
  localparam int SETTLE_CYCLES = 160;
  localparam opcode_t OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam word_t W_MAX = 32'sh7fffffff;
  localparam word_t W_MIN = 32'sh80000000;
  localparam uword_t U_MAX = 31'h7fffffff;

  typedef struct {
    word_t speed;
    word_t rate;
    word_t err;
    logic  en;
  } drive_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  ovtrk_cmd_if cmd_bus ();
  ovtrk_drv_if drv_bus ();

  oval_track_pid_steering #(.FRAC_BITS(FRAC), .SUM_WIDTH(SUM_W)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_bus),
    .drv     (drv_bus)
  );

  // predictor state
  word_t  cfg_speed = RST_SPEED;
  word_t  cfg_kp = RST_KP;
  word_t  cfg_ki = RST_KI;
  word_t  cfg_kd = RST_KD;
  uword_t cfg_thresh = RST_THRESH;
  uword_t cfg_half = RST_HALF;
  uword_t cfg_radius = RST_RADIUS;
  word_t  pose_x = '0;
  word_t  pose_y = '0;
  logic   obstacle = 1'b0;
  longint err_sum = 0;
  longint last_err = 0;

  drive_t pending_drives[$];
  int     fail_count = 0;
  bit     idle_on = 1'b0;
  int     rx_hold = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic note_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint isqrt64(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic longint oval_track_error();
    longint px, py, hx, rr, dx;
    logic [63:0] sq;
    px = pose_x;
    py = pose_y;
    hx = cfg_half;
    rr = cfg_radius;
    if (px > hx) dx = px - hx;
    else if (px < -hx) dx = px + hx;
    else if (py > 0) return sat_word(py - rr);
    else return sat_word(-rr - py);
    sq = dx * dx + py * py;
    return sat_word(isqrt64(sq) - rr);
  endfunction

  function automatic drive_t predict_drive();
    drive_t d;
    longint e, diff, smax, smin;
    logic signed [127:0] acc;
    if (obstacle) begin
      d.speed = '0;
      d.rate = '0;
      d.err = '0;
      d.en = 1'b0;
      return d;
    end
    e = oval_track_error();
    smax = (64'sd1 <<< (SUM_W - 1)) - 1;
    smin = -smax - 1;
    if (e > 0 && err_sum > smax - e) err_sum = smax;
    else if (e < 0 && err_sum < smin - e) err_sum = smin;
    else err_sum = err_sum + e;
    diff = e - last_err;
    last_err = e;
    acc = cfg_kp * e + cfg_ki * err_sum + cfg_kd * diff;
    acc = acc >>> FRAC;
    if (acc > 128'sd2147483647) d.rate = W_MAX;
    else if (acc < -128'sd2147483648) d.rate = W_MIN;
    else d.rate = acc[31:0];
    d.speed = cfg_speed;
    d.err = e[31:0];
    d.en = 1'b1;
    return d;
  endfunction

  task automatic apply_cmd(opcode_t op, word_t x, word_t y, uword_t r);
    case (op)
      OP_POSE: begin
        pose_x = x;
        pose_y = y;
      end
      OP_RANGE: if (r < cfg_thresh) obstacle = 1'b1;
      OP_TICK: pending_drives.push_back(predict_drive());
      default: ;
    endcase
  endtask

  task automatic send_cmd(opcode_t op, word_t x, word_t y, uword_t r);
    if (idle_on && $urandom_range(3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.opcode <= op;
    cmd_bus.pos_x <= x;
    cmd_bus.pos_y <= y;
    cmd_bus.range_value <= r;
    do @(posedge clk); while (!cmd_bus.ready);
    apply_cmd(op, x, y, r);
  endtask

  task automatic pose_tick(word_t x, word_t y);
    send_cmd(OP_POSE, x, y, $urandom);
    send_cmd(OP_TICK, $urandom, $urandom, $urandom);
  endtask

  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(logic wr, logic [2:0] idx, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic [2:0] idx);
    logic [31:0] got, want, mask;
    apb_xfer(1'b0, idx, 32'd0, got);
    mask = 32'hffffffff;
    case (idx)
      REG_SPEED: want = cfg_speed;
      REG_KP: want = cfg_kp;
      REG_KI: want = cfg_ki;
      REG_KD: want = cfg_kd;
      REG_THRESH: begin
        want = cfg_thresh;
        mask = 32'h7fffffff;
      end
      REG_HALF: begin
        want = cfg_half;
        mask = 32'h7fffffff;
      end
      REG_RADIUS: begin
        want = cfg_radius;
        mask = 32'h7fffffff;
      end
      default: want = got;
    endcase
    if ((got & mask) !== (want & mask)) note_mismatch("register readback", got, want);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] rd_dummy;
    apb_xfer(1'b1, idx, value, rd_dummy);
    case (idx)
      REG_SPEED: cfg_speed = value;
      REG_KP: cfg_kp = value;
      REG_KI: cfg_ki = value;
      REG_KD: cfg_kd = value;
      REG_THRESH: cfg_thresh = value[30:0];
      REG_HALF: cfg_half = value[30:0];
      REG_RADIUS: cfg_radius = value[30:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic randomize_regs(bit wide);
    write_reg(REG_SPEED, $urandom);
    if (wide) begin
      write_reg(REG_KP, $urandom);
      write_reg(REG_KI, $urandom);
      write_reg(REG_KD, $urandom);
      write_reg(REG_HALF, $urandom_range(32'h1000_0000));
      write_reg(REG_RADIUS, $urandom_range(32'h1000_0000));
    end else begin
      write_reg(REG_KP, $urandom_range(32'h8_0000) - 32'h4_0000);
      write_reg(REG_KI, $urandom_range(32'h8_0000) - 32'h4_0000);
      write_reg(REG_KD, $urandom_range(32'h8_0000) - 32'h4_0000);
      write_reg(REG_HALF, $urandom_range(32'h80_0000));
      write_reg(REG_RADIUS, $urandom_range(32'h80_0000));
    end
    write_reg(REG_THRESH, $urandom_range(32'h2_0000));
  endtask

  task automatic make_pose(output word_t x, output word_t y);
    longint lim, vx, vy;
    int mode;
    lim = longint'(cfg_half) + longint'(cfg_radius) + 262144;
    if (lim > 64'sd2147483647) lim = 64'sd2147483647;
    mode = $urandom_range(9);
    if (mode < 7) begin
      // around the track
      vx = $urandom_range(32'(lim));
      vy = $urandom_range(32'(lim));
      if ($urandom_range(1)) vx = -vx;
      if ($urandom_range(1)) vy = -vy;
      x = vx[31:0];
      y = vy[31:0];
    end else if (mode < 9) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = ($urandom_range(1)) ? W_MAX : W_MIN;
      y = ($urandom_range(1)) ? W_MIN : word_t'(0);
    end
  endtask

  task automatic random_items(int n);
    int sent, k;
    word_t px, py;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(99);
      if (k < 45) begin
        make_pose(px, py);
        send_cmd(OP_POSE, px, py, $urandom);
        sent++;
        repeat ($urandom_range(3, 1)) begin
          send_cmd(OP_TICK, $urandom, $urandom, $urandom);
          sent++;
        end
      end else if (k < 70) begin
        send_cmd(OP_RANGE, $urandom, $urandom, $urandom_range(U_MAX, cfg_thresh));
        sent++;
      end else if (k < 96) begin
        send_cmd(OP_TICK, $urandom, $urandom, $urandom);
        sent++;
      end else begin
        send_cmd(OP_UNUSED, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 7; i++) check_reg(3'(i));
  endtask

  task automatic test_directed_tracks();
    // tick at the origin, stray fields on the tick must not move the pose
    send_cmd(OP_TICK, W_MAX, W_MIN, U_MAX);
    pose_tick(0, cfg_radius);
    pose_tick(cfg_half, 100000);
    pose_tick(-cfg_half, -500000);
    pose_tick(cfg_half + 1, 0);
    pose_tick(-800000, 300000);
    send_cmd(OP_UNUSED, W_MIN, W_MAX, 0);
    send_cmd(OP_RANGE, 0, 0, cfg_thresh);
    send_cmd(OP_RANGE, -1, -1, U_MAX);
    pose_tick(W_MAX, W_MAX);
    pose_tick(W_MIN, W_MIN);
    send_cmd(OP_TICK, 0, 0, 0);
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SPEED, W_MIN);
    write_reg(REG_KP, W_MAX);
    write_reg(REG_KI, W_MIN);
    write_reg(REG_KD, W_MAX);
    write_reg(REG_THRESH, 32'd0);
    write_reg(REG_HALF, 32'd0);
    write_reg(REG_RADIUS, 32'd0);
    pose_tick(W_MAX, W_MAX);
    pose_tick(W_MIN, W_MIN);
    pose_tick(0, W_MIN);
    send_cmd(OP_RANGE, 0, 0, 0);
    send_cmd(OP_TICK, 0, 0, 0);
    settle();
    write_reg(REG_SPEED, W_MAX);
    write_reg(REG_KP, W_MIN);
    write_reg(REG_KI, W_MAX);
    write_reg(REG_KD, W_MIN);
    write_reg(REG_THRESH, 32'hffffffff);
    write_reg(REG_HALF, 32'hffffffff);
    write_reg(REG_RADIUS, 32'hffffffff);
    write_reg(REG_NONE, 32'h5a5a_a5a5);
    for (int i = 0; i < 7; i++) check_reg(3'(i));
    send_cmd(OP_RANGE, 0, 0, U_MAX);
    pose_tick(0, 0);
    pose_tick(W_MIN, W_MIN);
    pose_tick(W_MAX, 1);
    settle();
  endtask

  task automatic test_random_traffic(int n, bit wide);
    randomize_regs(wide);
    random_items(n);
    settle();
  endtask

  task automatic test_output_backpressure();
    rx_hold = 500;
    random_items(40);
    settle();
  endtask

  task automatic test_obstacle_stop();
    write_reg(REG_THRESH, 32'h10_0000);
    send_cmd(OP_RANGE, 0, 0, 31'h10_0000);
    pose_tick(700000, -200000);
    send_cmd(OP_RANGE, 0, 0, 31'h0f_ffff);
    send_cmd(OP_TICK, 0, 0, 0);
    pose_tick(W_MAX, W_MIN);
    send_cmd(OP_RANGE, 0, 0, U_MAX);
    send_cmd(OP_TICK, 0, 0, 0);
    random_items(20);
    settle();
  endtask

  // drive channel sink and checker
  initial begin : drive_sink
    int stall;
    drive_t want;
    stall = 0;
    drv_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && drv_bus.valid && drv_bus.ready) begin
        if (pending_drives.size() == 0) begin
          note_mismatch("unexpected drive transaction", drv_bus.track_error, 0);
        end else begin
          want = pending_drives.pop_front();
          if (drv_bus.linear_speed !== want.speed)
            note_mismatch("linear_speed", drv_bus.linear_speed, want.speed);
          if (drv_bus.angular_rate !== want.rate)
            note_mismatch("angular_rate", drv_bus.angular_rate, want.rate);
          if (drv_bus.track_error !== want.err)
            note_mismatch("track_error", drv_bus.track_error, want.err);
          if (drv_bus.drive_enabled !== want.en)
            note_mismatch("drive_enabled", drv_bus.drive_enabled, want.en);
        end
      end
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        drv_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall = stall - 1;
        drv_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(4) == 0) begin
        stall = $urandom_range(6);
        drv_bus.ready <= 1'b0;
      end else begin
        drv_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.opcode <= OP_TICK;
    cmd_bus.pos_x <= '0;
    cmd_bus.pos_y <= '0;
    cmd_bus.range_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_tracks();
    idle_on = 1'b1;
    test_register_extremes();
    test_random_traffic(260, 1'b0);
    test_random_traffic(260, 1'b1);
    test_output_backpressure();
    test_random_traffic(240, 1'b0);
    idle_on = 1'b0;
    test_random_traffic(200, 1'b0);
    test_obstacle_stop();
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
